FILE: rtl/ema_error_threshold_trigger_macros.svh
// Assertion macros shared by the checker of the velocity error detector.
// No dependencies; included by the files that assert.
`ifndef EMA_ERROR_THRESHOLD_TRIGGER_MACROS_SVH
`define EMA_ERROR_THRESHOLD_TRIGGER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define EETT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Property checked at every clock edge, reset included.
`define EETT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/eett_pkg.sv
// Shared types and constants of the velocity error threshold detector.
// No dependencies; used by the controller, the datapath and the top level.
package eett_pkg;

  localparam int VEL_WIDTH = 16;
  localparam int ERR_W = 16;
  localparam int SUM_W = 24;
  localparam int TICK_W = 9;
  localparam int WL_W = 8;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [15:0] ALPHA_RESET = 16'd3932;
  localparam logic [15:0] THRESHOLD_RESET = 16'd287;
  localparam logic [7:0] WARMUP_RESET = 8'd25;

  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WARMUP = 2'd2;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] threshold;
    logic [WL_W-1:0] warmup_len;
  } cfg_t;

  typedef struct packed {
    logic cap_in;
    logic ld_err;
    logic ld_sum;
    logic div_step;
    logic ld_wavg;
    logic mul1;
    logic mul2;
    logic cmp;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic warm;
  } status_t;

endpackage

FILE: rtl/eett_ctrl.sv
// Sequencing state machine of the velocity error threshold detector.
// Depends on eett_pkg for the command and status structs.
module eett_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  eett_pkg::status_t  status,
  output eett_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_WAVG = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [eett_pkg::DIV_CNT_W-1:0] cnt;
  logic [eett_pkg::DIV_CNT_W-1:0] cnt_next;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.cap_in = in_valid;
        if (in_valid) state_next = S_ERR;
      end
      S_ERR: begin
        cmd.ld_err = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        if (status.warm) begin
          state_next = S_SUM;
        end else begin
          cmd.mul1 = 1'b1;
          state_next = S_MUL2;
        end
      end
      S_SUM: begin
        cmd.ld_sum = 1'b1;
        cnt_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == eett_pkg::DIV_CNT_W'(eett_pkg::DIV_STEPS - 1)) state_next = S_WAVG;
      end
      S_WAVG: begin
        cmd.ld_wavg = 1'b1;
        state_next = S_FIN;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/eett_dp.sv
// Datapath of the velocity error threshold detector: error, sum, divider, moving
// average and threshold compare. Depends on eett_pkg; driven by commands from eett_ctrl.
module eett_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  eett_pkg::cmd_t                    cmd,
  output eett_pkg::status_t                 status,
  input  eett_pkg::cfg_t                    cfg,
  input  logic signed [eett_pkg::VEL_WIDTH-1:0] target_velocity,
  input  logic signed [eett_pkg::VEL_WIDTH-1:0] actual_velocity,
  output logic [eett_pkg::ERR_W-1:0]        average_error,
  output logic                              switch_pulse
);

  localparam int MAG_W = eett_pkg::VEL_WIDTH + 1;
  localparam int EXT_W = (MAG_W > 17) ? MAG_W : 17;

  logic signed [eett_pkg::VEL_WIDTH-1:0] tgt;
  logic signed [eett_pkg::VEL_WIDTH-1:0] act;
  logic [eett_pkg::ERR_W-1:0] err;
  logic [eett_pkg::TICK_W-1:0] tick_count;
  logic [eett_pkg::SUM_W-1:0] error_sum;
  logic [15:0] running_average;
  logic pulse;
  logic [eett_pkg::SUM_W-1:0] quo;
  logic [eett_pkg::WL_W-1:0] rem;
  logic [31:0] prod1;

  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0] mag;
  logic [EXT_W-1:0] mag_ext;
  logic [eett_pkg::ERR_W-1:0] err_sat;
  logic [eett_pkg::SUM_W:0] sum_wide;
  logic [eett_pkg::SUM_W-1:0] sum_sat;
  logic [eett_pkg::WL_W:0] trial;
  logic trial_ge;
  logic [16:0] beta;
  logic [32:0] prod2;
  logic [33:0] acc;

  assign diff = MAG_W'(tgt) - MAG_W'(act);
  assign mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign mag_ext = EXT_W'(mag);
  assign err_sat = (mag_ext > EXT_W'(17'hFFFF)) ? 16'hFFFF : mag_ext[15:0];

  assign sum_wide = {1'b0, error_sum} + (eett_pkg::SUM_W + 1)'(err);
  assign sum_sat = sum_wide[eett_pkg::SUM_W] ? '1 : sum_wide[eett_pkg::SUM_W-1:0];

  assign trial = {rem, quo[eett_pkg::SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, cfg.warmup_len});

  assign beta = 17'h10000 - {1'b0, cfg.alpha};
  assign prod2 = beta * running_average;
  assign acc = {2'b00, prod1} + {1'b0, prod2} + 34'd32768;

  assign status.warm = (tick_count <= {1'b0, cfg.warmup_len});

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= eett_pkg::TICK_W'(1);
      error_sum <= '0;
      running_average <= '0;
    end else begin
      if (cmd.ld_sum) begin
        error_sum <= sum_sat;
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.ld_wavg) begin
        running_average <= (|quo[eett_pkg::SUM_W-1:16]) ? 16'hFFFF : quo[15:0];
      end
      if (cmd.mul2) begin
        running_average <= (|acc[33:32]) ? 16'hFFFF : acc[31:16];
      end
      if (cmd.cmp && (running_average > cfg.threshold)) begin
        tick_count <= eett_pkg::TICK_W'(1);
        error_sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      tgt <= target_velocity;
      act <= actual_velocity;
    end
    if (cmd.ld_err) begin
      err <= err_sat;
      pulse <= 1'b0;
    end
    if (cmd.cmp) pulse <= (running_average > cfg.threshold);
    if (cmd.ld_sum) begin
      quo <= sum_sat;
      rem <= '0;
    end
    if (cmd.div_step) begin
      quo <= {quo[eett_pkg::SUM_W-2:0], trial_ge};
      rem <= trial_ge ? eett_pkg::WL_W'(trial - {1'b0, cfg.warmup_len})
                      : trial[eett_pkg::WL_W-1:0];
    end
    if (cmd.mul1) prod1 <= cfg.alpha * err;
    if (cmd.ld_out) begin
      average_error <= running_average;
      switch_pulse <= pulse;
    end
  end

endmodule

FILE: rtl/ema_error_threshold_trigger.sv
// Velocity error averaging detector: one item in, one result item out.
// Warm-up items pass through the 24-step restoring divider; moving-average items take
// the multiply and compare path. A new item is accepted only after the last result is
// loaded for output, which waits while an earlier result waits for m_tready.
// Synchronous active-high reset restores register defaults, the tick count to
// one, sum and average to zero. Depends on eett_pkg, eett_ctrl and eett_dp.
module ema_error_threshold_trigger (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] target_velocity, [31:16] actual_velocity
  input  logic [2*eett_pkg::VEL_WIDTH-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] average_error
  output logic [15:0] m_tdata,
  // [0] switch_pulse
  output logic [0:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  eett_pkg::cfg_t cfg;
  eett_pkg::cmd_t cmd;
  eett_pkg::status_t status;
  logic wr_en;
  logic pulse_out;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha <= eett_pkg::ALPHA_RESET;
      cfg.threshold <= eett_pkg::THRESHOLD_RESET;
      cfg.warmup_len <= eett_pkg::WARMUP_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        eett_pkg::REG_ALPHA:     cfg.alpha <= pwdata[15:0];
        eett_pkg::REG_THRESHOLD: cfg.threshold <= pwdata[15:0];
        eett_pkg::REG_WARMUP:    cfg.warmup_len <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      eett_pkg::REG_ALPHA:     prdata = {16'd0, cfg.alpha};
      eett_pkg::REG_THRESHOLD: prdata = {16'd0, cfg.threshold};
      eett_pkg::REG_WARMUP:    prdata = {24'd0, cfg.warmup_len};
      default:                 prdata = '0;
    endcase
  end

  eett_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  eett_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg             (cfg),
    .target_velocity (s_tdata[eett_pkg::VEL_WIDTH-1:0]),
    .actual_velocity (s_tdata[2*eett_pkg::VEL_WIDTH-1:eett_pkg::VEL_WIDTH]),
    .average_error   (m_tdata),
    .switch_pulse    (pulse_out)
  );

  assign m_tuser = pulse_out;

endmodule

FILE: rtl/eett_checker.sv
// Port-level checks of the velocity error threshold detector, bound to the
// top level. Depends on ema_error_threshold_trigger_macros.svh.
`include "ema_error_threshold_trigger_macros.svh"

module eett_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  `EETT_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `EETT_ASSERT(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `EETT_ASSERT(a_pulse_nonzero_avg, clk, rst, m_tvalid && m_tuser[0] |-> m_tdata != 16'd0)
  `EETT_ASSERT_ALWAYS(a_reset_clears_out, clk, $past(rst) |-> !m_tvalid)

endmodule

bind ema_error_threshold_trigger eett_checker u_eett_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: test/ema_error_threshold_trigger_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ema_error_threshold_trigger: a predictor of the error
// average and switch pulse checks every result item. Depends on eett_pkg and the block.
module ema_error_threshold_trigger_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 94;

  typedef struct packed {
    logic [15:0] average;
    logic        pulse;
  } tick_result_t;

  class ema_trigger_predictor;
    logic [15:0] alpha;
    logic [15:0] threshold;
    logic [7:0]  warmup_len;
    logic [8:0]  tick_count;
    logic [23:0] error_sum;
    logic [15:0] running_avg;
    tick_result_t expected_ticks[$];
    int mismatch_count;

    function new();
      alpha = eett_pkg::ALPHA_RESET;
      threshold = eett_pkg::THRESHOLD_RESET;
      warmup_len = eett_pkg::WARMUP_RESET;
      tick_count = 9'd1;
      error_sum = '0;
      running_avg = '0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        eett_pkg::REG_ALPHA: alpha = value[15:0];
        eett_pkg::REG_THRESHOLD: threshold = value[15:0];
        eett_pkg::REG_WARMUP: warmup_len = value[7:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic signed [15:0] target, logic signed [15:0] actual);
      int diff;
      longint unsigned err;
      longint unsigned acc;
      longint unsigned a64;
      tick_result_t res;
      diff = int'(target) - int'(actual);
      err = (diff < 0) ? longint'(-diff) : longint'(diff);
      if (err > 65535) err = 65535;
      res.pulse = 1'b0;
      if (tick_count <= {1'b0, warmup_len}) begin
        acc = longint'(error_sum) + err;
        if (acc > 64'hFF_FFFF) acc = 64'hFF_FFFF;
        error_sum = acc[23:0];
        acc = acc / warmup_len;
        running_avg = (acc > 65535) ? 16'hFFFF : acc[15:0];
        tick_count = tick_count + 9'd1;
      end else begin
        a64 = alpha;
        acc = a64 * err + (64'd65536 - a64) * running_avg + 64'd32768;
        acc = acc >> 16;
        running_avg = (acc > 65535) ? 16'hFFFF : acc[15:0];
        if (running_avg > threshold) begin
          res.pulse = 1'b1;
          tick_count = 9'd1;
          error_sum = '0;
        end
      end
      res.average = running_avg;
      expected_ticks.push_back(res);
    endfunction

    function void check_tick(logic [15:0] average, logic pulse);
      tick_result_t want;
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected result item: average %0d pulse %0d", $time, average, pulse);
        mismatch_count++;
        return;
      end
      want = expected_ticks.pop_front();
      if (average !== want.average) begin
        $display("%0t: average_error mismatch: expected %0d actual %0d",
                 $time, want.average, average);
        mismatch_count++;
      end
      if (pulse !== want.pulse) begin
        $display("%0t: switch_pulse mismatch: expected %0d actual %0d",
                 $time, want.pulse, pulse);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  ema_trigger_predictor trigger_model;

  ema_error_threshold_trigger DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      trigger_model.note_tick($signed(s_tdata[15:0]), $signed(s_tdata[31:16]));
    if (!rst && m_tvalid && m_tready)
      trigger_model.check_tick(m_tdata, m_tuser[0]);
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  task automatic send_tick(input logic [15:0] t_vel, input logic [15:0] a_vel);
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = $urandom;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {a_vel, t_vel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (trigger_model.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    trigger_model.set_register(idx, value);
  endtask

  task automatic pick_velocities(input int unsigned spread, output logic [15:0] t_vel,
                                 output logic [15:0] a_vel);
    int unsigned mode;
    logic signed [15:0] b16;
    int base;
    int other;
    mode = $urandom_range(19);
    b16 = 16'($urandom);
    base = int'(b16);
    if (mode < 3) begin
      t_vel = 16'($urandom);
      a_vel = 16'($urandom);
    end else if (mode < 18) begin
      other = base + int'($urandom_range(2 * spread)) - int'(spread);
      if (other > 32767) other = 32767;
      if (other < -32768) other = -32768;
      t_vel = base[15:0];
      a_vel = other[15:0];
    end else if (mode == 18) begin
      t_vel = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      a_vel = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    end else begin
      t_vel = base[15:0];
      a_vel = base[15:0];
    end
  endtask

  initial begin
    logic [15:0] t_vel;
    logic [15:0] a_vel;
    logic [15:0] new_alpha;
    logic [15:0] new_threshold;
    logic [7:0]  new_warmup;
    int unsigned spread;

    trigger_model = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_tick(16'h7FFF, 16'h8000);
    send_tick(16'h8000, 16'h7FFF);
    send_tick(16'h0000, 16'h0000);
    wait_drained();
    write_reg(eett_pkg::REG_WARMUP, 32'd1);
    write_reg(eett_pkg::REG_ALPHA, 32'hFFFF_FFFF);
    write_reg(eett_pkg::REG_THRESHOLD, 32'h1234_FFFF);
    write_reg(REG_UNUSED, 32'h0000_0005);
    send_tick(16'h7FFF, 16'h8000);
    send_tick(16'h0000, 16'h0000);
    send_tick(16'hFFFF, 16'h0000);
    wait_drained();
    write_reg(eett_pkg::REG_ALPHA, 32'd0);
    write_reg(eett_pkg::REG_THRESHOLD, 32'd0);
    send_tick(16'h0000, 16'h0000);
    send_tick(16'h1234, 16'hEDCC);
    send_tick(16'h0000, 16'h0000);
    wait_drained();
    write_reg(eett_pkg::REG_WARMUP, 32'hFFFF_FF00);
    write_reg(eett_pkg::REG_ALPHA, 32'h0000_8000);
    write_reg(eett_pkg::REG_THRESHOLD, 32'd100);
    send_tick(16'd100, 16'd0);
    send_tick(16'd0, 16'd0);
    send_tick(16'd0, 16'd0);
    send_tick(16'd0, 16'd0);
    send_tick(16'hFFFB, 16'd5);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin new_alpha = eett_pkg::ALPHA_RESET; new_threshold = eett_pkg::THRESHOLD_RESET;
                 new_warmup = eett_pkg::WARMUP_RESET; end
        1: begin new_alpha = 16'hFFFF; new_threshold = 16'd0; new_warmup = 8'd1; end
        2: begin new_alpha = 16'd0; new_threshold = 16'hFFFF; new_warmup = 8'd255; end
        3: begin new_alpha = 16'($urandom); new_threshold = 16'($urandom_range(4000));
                 new_warmup = 8'($urandom_range(40, 1)); end
        4: begin new_alpha = 16'd1000; new_threshold = 16'd2000; new_warmup = 8'd0; end
        5: begin new_alpha = 16'd40000; new_threshold = 16'($urandom); new_warmup = 8'd8; end
        6: begin new_alpha = 16'($urandom); new_threshold = 16'($urandom);
                 new_warmup = 8'($urandom); end
        default: begin new_alpha = 16'($urandom_range(8000));
                 new_threshold = 16'($urandom_range(1000));
                 new_warmup = 8'($urandom_range(12)); end
      endcase
      write_reg(eett_pkg::REG_ALPHA, {16'($urandom), new_alpha});
      write_reg(eett_pkg::REG_THRESHOLD, {16'($urandom), new_threshold});
      write_reg(eett_pkg::REG_WARMUP, {24'($urandom), new_warmup});
      case (seg % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (seg == 2) hold_left = 500;
      spread = (int'(new_threshold) * 3) / 2 + 16;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        pick_velocities(spread, t_vel, a_vel);
        send_tick(t_vel, a_vel);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (trigger_model.mismatch_count == 0 && trigger_model.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/eett_pkg.sv
rtl/eett_ctrl.sv
rtl/eett_dp.sv
rtl/ema_error_threshold_trigger.sv
rtl/eett_checker.sv
test/ema_error_threshold_trigger_tb.sv
